@@ rtl/rgbc_colour_classifier_assert.svh @@
// ----------------------------------------------------------------------------
// RGBC colour classifier assertion macros
// Concurrent assertion helpers clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef RGBC_COLOUR_CLASSIFIER_ASSERT_SVH
`define RGBC_COLOUR_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RGBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgbc_colour_classifier: assertion failed");
// Next-cycle implication.
`define RGBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgbc_colour_classifier: assertion failed");
`else
`define RGBC_ASSERT_NOW(lbl, ante, cons)
`define RGBC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/rgbc_pkg.sv @@
// ----------------------------------------------------------------------------
// RGBC colour classifier package
// Payload types, register indexes, colour codes and fixed-point constants.
// ----------------------------------------------------------------------------
package rgbc_pkg;

    // Fixed point: Q16 fractions.
    localparam int          FRAC_BITS = 16;
    localparam logic [16:0] ONE       = 17'h10000;

    // Accepted colour counts are 1..VALID_MAX, so ten bits carry them.
    localparam logic [15:0] VALID_MAX = 16'd1022;
    localparam int          CH_W      = 10;

    // Restoring divider step counts, one quotient bit per stage.
    localparam int W_STEPS = 17;
    localparam int C_STEPS = 27;
    localparam int N_STEPS = 18;
    localparam int R_STEPS = 24;

    // Ratio saturation, grey gain and grey clamp.
    localparam logic [22:0] Q_MAX     = 23'h400000;
    localparam logic [29:0] GREY_GAIN = 30'd1000;
    localparam logic [20:0] T_MAX     = 21'h100000;
    localparam int          SCORE_W   = 29;

    // Colour codes.
    localparam logic [3:0] CLS_UNKNOWN = 4'd8;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CLEAR_BLACK = 3'd0,
        REG_RED_BLACK   = 3'd1,
        REG_GREEN_BLACK = 3'd2,
        REG_BLUE_BLACK  = 3'd3,
        REG_CLEAR_WHITE = 3'd4,
        REG_RED_WHITE   = 3'd5,
        REG_GREEN_WHITE = 3'd6,
        REG_BLUE_WHITE  = 3'd7
    } t_reg_idx;

    // One input item.
    typedef struct packed {
        logic [15:0] clear_count;
        logic [15:0] red_count;
        logic [15:0] green_count;
        logic [15:0] blue_count;
    } t_rgbc_in;

    // One result item.
    typedef struct packed {
        logic [3:0] colour_class;
        logic       reading_rejected;
    } t_rgbc_out;

    // A zero calibration count is read as one.
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

@@ rtl/rgbc_colour_classifier.sv @@
// ----------------------------------------------------------------------------
// RGBC colour classifier
// Classifies one clear/red/green/blue reading into a colour class.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while the output side does not
// stall. The pipeline is built around four restoring dividers that make one
// quotient bit per stage: the brightness weight (17 stages), the calibration
// scaling (27), the normalisation (18) and the ratio and grey scores (24). A
// stall at the output freezes the whole pipeline; nothing inside is lost or
// repeated. Calibration registers are written through the plain write port and
// must only change while no item is in flight.
`include "rgbc_colour_classifier_assert.svh"

module rgbc_colour_classifier (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rgbc_pkg::t_rgbc_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rgbc_pkg::t_rgbc_out o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_wdata
);
    import rgbc_pkg::*;

    localparam int LAT = (W_STEPS + 1) + (C_STEPS + 1) + (N_STEPS + 1) + 4 + (R_STEPS + 1) + 3;

    typedef struct packed {
        logic            rej;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_xcry;

    typedef struct packed {
        logic        rej;
        logic [16:0] w;
        logic [16:0] b;
    } t_wcry;

    typedef struct packed {
        logic        rej;
        logic [16:0] w;
        logic [16:0] b;
        logic [27:0] sum;
    } t_ncry;

    // Calibration registers.
    logic [15:0] r_clear_black, r_red_black, r_green_black, r_blue_black;
    logic [15:0] r_clear_white, r_red_white, r_green_white, r_blue_white;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_black <= 16'd0;
            r_red_black   <= 16'd1;
            r_green_black <= 16'd1;
            r_blue_black  <= 16'd1;
            r_clear_white <= 16'd65535;
            r_red_white   <= 16'd1023;
            r_green_white <= 16'd1023;
            r_blue_white  <= 16'd1023;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CLEAR_BLACK: r_clear_black <= i_cfg_wdata;
                REG_RED_BLACK:   r_red_black   <= i_cfg_wdata;
                REG_GREEN_BLACK: r_green_black <= i_cfg_wdata;
                REG_BLUE_BLACK:  r_blue_black  <= i_cfg_wdata;
                REG_CLEAR_WHITE: r_clear_white <= i_cfg_wdata;
                REG_RED_WHITE:   r_red_white   <= i_cfg_wdata;
                REG_GREEN_WHITE: r_green_white <= i_cfg_wdata;
                REG_BLUE_WHITE:  r_blue_white  <= i_cfg_wdata;
                default:         r_clear_black <= r_clear_black;
            endcase
        end
    end

    // Values derived from the calibration; they are static while items flow.
    logic [15:0] w_den;
    logic        w_zero, w_full;
    logic [15:0] c_den [6];

    always_comb begin
        w_den    = r_clear_white - r_clear_black;
        w_zero   = (r_clear_white == r_clear_black);
        w_full   = (r_clear_white < r_clear_black);
        c_den[0] = at_least_one(r_red_white);
        c_den[1] = at_least_one(r_green_white);
        c_den[2] = at_least_one(r_blue_white);
        c_den[3] = at_least_one(r_red_black);
        c_den[4] = at_least_one(r_green_black);
        c_den[5] = at_least_one(r_blue_black);
    end

    // Pipeline advance and valid bits.
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en          = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------------
    // Input stage and brightness weight divider.
    // ------------------------------------------------------------------------
    logic        a_rej;
    logic [15:0] a_ct0, a_ct;

    always_comb begin
        a_rej = (i_in_data.red_count == 16'd0) || (i_in_data.red_count > VALID_MAX) ||
                (i_in_data.green_count == 16'd0) || (i_in_data.green_count > VALID_MAX) ||
                (i_in_data.blue_count == 16'd0) || (i_in_data.blue_count > VALID_MAX);
        a_ct0 = (i_in_data.clear_count < r_clear_black) ? r_clear_black
                                                        : i_in_data.clear_count;
        a_ct  = (a_ct0 > r_clear_white) ? r_clear_white : a_ct0;
    end

    logic [31:0] r_w_rem [W_STEPS+1];
    logic [16:0] r_w_q   [W_STEPS+1];
    t_xcry       r_w_cry [W_STEPS+1];
    logic [31:0] n_w_rem [W_STEPS];
    logic [16:0] n_w_q   [W_STEPS];

    // One quotient bit per stage, most significant first.
    always_comb begin
        logic [31:0] dsh;
        for (int j = 0; j < W_STEPS; j++) begin
            dsh = 32'(w_den) << (W_STEPS - 1 - j);
            if (r_w_rem[j] >= dsh) begin
                n_w_rem[j] = r_w_rem[j] - dsh;
                n_w_q[j]   = r_w_q[j] | (17'(1) << (W_STEPS - 1 - j));
            end else begin
                n_w_rem[j] = r_w_rem[j];
                n_w_q[j]   = r_w_q[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w_rem[0] <= {a_ct - r_clear_black, 16'h0000};
            r_w_q[0]   <= '0;
            r_w_cry[0] <= '{rej: a_rej,
                            r:   i_in_data.red_count[CH_W-1:0],
                            g:   i_in_data.green_count[CH_W-1:0],
                            b:   i_in_data.blue_count[CH_W-1:0]};
            for (int j = 0; j < W_STEPS; j++) begin
                r_w_rem[j+1] <= n_w_rem[j];
                r_w_q[j+1]   <= n_w_q[j];
                r_w_cry[j+1] <= r_w_cry[j];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Channel products and calibration scaling divider (six lanes).
    // ------------------------------------------------------------------------
    logic [16:0] m_w, m_b;

    always_comb begin
        if (w_zero) begin
            m_w = 17'd0;
        end else if (w_full) begin
            m_w = ONE;
        end else begin
            m_w = r_w_q[W_STEPS];
        end
        m_b = ONE - m_w;
    end

    logic [26:0] r_c_rem [C_STEPS+1][6];
    logic [26:0] r_c_q   [C_STEPS+1][6];
    t_wcry       r_c_cry [C_STEPS+1];
    logic [26:0] n_c_rem [C_STEPS][6];
    logic [26:0] n_c_q   [C_STEPS][6];

    always_comb begin
        logic [41:0] dsh;
        for (int j = 0; j < C_STEPS; j++) begin
            for (int l = 0; l < 6; l++) begin
                dsh = 42'(c_den[l]) << (C_STEPS - 1 - j);
                if (42'(r_c_rem[j][l]) >= dsh) begin
                    n_c_rem[j][l] = r_c_rem[j][l] - dsh[26:0];
                    n_c_q[j][l]   = r_c_q[j][l] | (27'(1) << (C_STEPS - 1 - j));
                end else begin
                    n_c_rem[j][l] = r_c_rem[j][l];
                    n_c_q[j][l]   = r_c_q[j][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_rem[0][0] <= 27'(r_w_cry[W_STEPS].r) * 27'(m_w);
            r_c_rem[0][1] <= 27'(r_w_cry[W_STEPS].g) * 27'(m_w);
            r_c_rem[0][2] <= 27'(r_w_cry[W_STEPS].b) * 27'(m_w);
            r_c_rem[0][3] <= 27'(r_w_cry[W_STEPS].r) * 27'(m_b);
            r_c_rem[0][4] <= 27'(r_w_cry[W_STEPS].g) * 27'(m_b);
            r_c_rem[0][5] <= 27'(r_w_cry[W_STEPS].b) * 27'(m_b);
            for (int l = 0; l < 6; l++) begin
                r_c_q[0][l] <= '0;
            end
            r_c_cry[0] <= '{rej: r_w_cry[W_STEPS].rej, w: m_w, b: m_b};
            for (int j = 0; j < C_STEPS; j++) begin
                r_c_rem[j+1] <= n_c_rem[j];
                r_c_q[j+1]   <= n_c_q[j];
                r_c_cry[j+1] <= r_c_cry[j];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Channel sums and normalisation divider (three lanes).
    // ------------------------------------------------------------------------
    logic [26:0] s_ch [3];
    logic [27:0] s_ch3 [3];
    logic [27:0] s_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_ch[i]  = r_c_q[C_STEPS][i] + r_c_q[C_STEPS][i+3];
            s_ch3[i] = {s_ch[i], 1'b0} + 28'(s_ch[i]);
        end
        s_sum = 28'(s_ch[0]) + 28'(s_ch[1]) + 28'(s_ch[2]);
    end

    logic [43:0] r_n_rem [N_STEPS+1][3];
    logic [17:0] r_n_q   [N_STEPS+1][3];
    t_ncry       r_n_cry [N_STEPS+1];
    logic [43:0] n_n_rem [N_STEPS][3];
    logic [17:0] n_n_q   [N_STEPS][3];

    always_comb begin
        logic [44:0] dsh;
        for (int j = 0; j < N_STEPS; j++) begin
            dsh = 45'(r_n_cry[j].sum) << (N_STEPS - 1 - j);
            for (int l = 0; l < 3; l++) begin
                if (45'(r_n_rem[j][l]) >= dsh) begin
                    n_n_rem[j][l] = r_n_rem[j][l] - dsh[43:0];
                    n_n_q[j][l]   = r_n_q[j][l] | (18'(1) << (N_STEPS - 1 - j));
                end else begin
                    n_n_rem[j][l] = r_n_rem[j][l];
                    n_n_q[j][l]   = r_n_q[j][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_n_rem[0][l] <= {s_ch3[l], 16'h0000};
                r_n_q[0][l]   <= '0;
            end
            r_n_cry[0] <= '{rej: r_c_cry[C_STEPS].rej, w: r_c_cry[C_STEPS].w,
                            b: r_c_cry[C_STEPS].b, sum: s_sum};
            for (int j = 0; j < N_STEPS; j++) begin
                r_n_rem[j+1] <= n_n_rem[j];
                r_n_q[j+1]   <= n_n_q[j];
                r_n_cry[j+1] <= r_n_cry[j];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Grey factor preparation: distances from one, their product and clamp.
    // ------------------------------------------------------------------------
    logic [17:0] r_p1_n [3];
    t_wcry       r_p1_cry;
    logic [17:0] p2_d [3];
    logic [18:0] r_p2_t1;
    logic [17:0] r_p2_db;
    logic [17:0] r_p2_n [3];
    t_wcry       r_p2_cry;
    logic [19:0] r_p3_t2;
    logic [17:0] r_p3_n [3];
    t_wcry       r_p3_cry;
    logic [29:0] p4_tg;
    logic [20:0] r_p4_t;
    logic [17:0] r_p4_n [3];
    t_wcry       r_p4_cry;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p2_d[i] = (r_p1_n[i] >= 18'(ONE)) ? r_p1_n[i] - 18'(ONE)
                                              : 18'(ONE) - r_p1_n[i];
        end
        p4_tg = 30'(r_p3_t2) * GREY_GAIN;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // All channels zero gives equal thirds.
            for (int i = 0; i < 3; i++) begin
                r_p1_n[i] <= (r_n_cry[N_STEPS].sum == 28'd0) ? 18'(ONE)
                                                             : r_n_q[N_STEPS][i];
            end
            r_p1_cry <= '{rej: r_n_cry[N_STEPS].rej, w: r_n_cry[N_STEPS].w,
                          b: r_n_cry[N_STEPS].b};

            r_p2_t1  <= 19'((36'(p2_d[0]) * 36'(p2_d[1])) >> FRAC_BITS);
            r_p2_db  <= p2_d[2];
            r_p2_n   <= r_p1_n;
            r_p2_cry <= r_p1_cry;

            r_p3_t2  <= 20'((37'(r_p2_t1) * 37'(r_p2_db)) >> FRAC_BITS);
            r_p3_n   <= r_p2_n;
            r_p3_cry <= r_p2_cry;

            r_p4_t   <= (p4_tg > 30'(T_MAX)) ? T_MAX : p4_tg[20:0];
            r_p4_n   <= r_p3_n;
            r_p4_cry <= r_p3_cry;
        end
    end

    // ------------------------------------------------------------------------
    // Ratio and grey divider: lanes 0..5 are the hue ratios, lane 6 is grey.
    // ------------------------------------------------------------------------
    logic [18:0] q_num [7];
    logic [24:0] q_den [7];
    logic [24:0] q_tt;
    logic [16:0] q_ww, q_bb;

    always_comb begin
        q_tt     = 25'((42'(r_p4_t) * 42'(r_p4_t)) >> FRAC_BITS);
        q_ww     = 17'((34'(r_p4_cry.w) * 34'(r_p4_cry.w)) >> FRAC_BITS);
        q_bb     = 17'((34'(r_p4_cry.b) * 34'(r_p4_cry.b)) >> FRAC_BITS);
        q_num[0] = {r_p4_n[0], 1'b0};
        q_den[0] = 25'(19'(r_p4_n[1]) + 19'(r_p4_n[2]));
        q_num[1] = 19'(r_p4_n[0]) + 19'(r_p4_n[1]);
        q_den[1] = 25'({r_p4_n[2], 1'b0});
        q_num[2] = {r_p4_n[1], 1'b0};
        q_den[2] = 25'(19'(r_p4_n[0]) + 19'(r_p4_n[2]));
        q_num[3] = 19'(r_p4_n[1]) + 19'(r_p4_n[2]);
        q_den[3] = 25'({r_p4_n[0], 1'b0});
        q_num[4] = {r_p4_n[2], 1'b0};
        q_den[4] = 25'(19'(r_p4_n[0]) + 19'(r_p4_n[1]));
        q_num[5] = 19'(r_p4_n[2]) + 19'(r_p4_n[0]);
        q_den[5] = 25'({r_p4_n[1], 1'b0});
        q_num[6] = 19'(ONE);
        q_den[6] = 25'(ONE) + q_tt;
    end

    logic [34:0] r_r_rem [R_STEPS+1][7];
    logic [24:0] r_r_den [R_STEPS+1][7];
    logic [23:0] r_r_q   [R_STEPS+1][7];
    t_wcry       r_r_cry [R_STEPS+1];
    logic [34:0] n_r_rem [R_STEPS][7];
    logic [23:0] n_r_q   [R_STEPS][7];

    // The top step catches quotients of 2^23 and more, including a zero
    // divisor; those saturate later.
    always_comb begin
        logic [47:0] dsh;
        for (int j = 0; j < R_STEPS; j++) begin
            for (int l = 0; l < 7; l++) begin
                dsh = 48'(r_r_den[j][l]) << (R_STEPS - 1 - j);
                if (48'(r_r_rem[j][l]) >= dsh) begin
                    n_r_rem[j][l] = r_r_rem[j][l] - dsh[34:0];
                    n_r_q[j][l]   = r_r_q[j][l] | (24'(1) << (R_STEPS - 1 - j));
                end else begin
                    n_r_rem[j][l] = r_r_rem[j][l];
                    n_r_q[j][l]   = r_r_q[j][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 7; l++) begin
                r_r_rem[0][l] <= {q_num[l], 16'h0000};
                r_r_den[0][l] <= q_den[l];
                r_r_q[0][l]   <= '0;
            end
            r_r_cry[0] <= '{rej: r_p4_cry.rej, w: q_ww, b: q_bb};
            for (int j = 0; j < R_STEPS; j++) begin
                r_r_rem[j+1] <= n_r_rem[j];
                r_r_den[j+1] <= r_r_den[j];
                r_r_q[j+1]   <= n_r_q[j];
                r_r_cry[j+1] <= r_r_cry[j];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Scores, then the first score above the running best in two halves.
    // ------------------------------------------------------------------------
    logic [22:0]        k_qc [6];
    logic [16:0]        k_grey;
    logic [SCORE_W-1:0] r_k_s [8];
    logic               r_k_rej;

    always_comb begin
        for (int l = 0; l < 6; l++) begin
            k_qc[l] = (r_r_q[R_STEPS][l] > 24'(Q_MAX)) ? Q_MAX : r_r_q[R_STEPS][l][22:0];
        end
        k_grey = r_r_q[R_STEPS][6][16:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                r_k_s[l] <= SCORE_W'((46'(k_qc[l]) * 46'(k_qc[l])) >> FRAC_BITS);
            end
            r_k_s[6] <= SCORE_W'((34'(r_r_cry[R_STEPS].w) * 34'(k_grey)) >> FRAC_BITS) << 2;
            r_k_s[7] <= SCORE_W'((34'(r_r_cry[R_STEPS].b) * 34'(k_grey)) >> FRAC_BITS) << 2;
            r_k_rej  <= r_r_cry[R_STEPS].rej;
        end
    end

    logic [SCORE_W-1:0] h_best;
    logic [3:0]         h_idx;
    logic [SCORE_W-1:0] r_h_best;
    logic [3:0]         r_h_idx;
    logic [SCORE_W-1:0] r_h_s [4];
    logic               r_h_rej;
    logic [SCORE_W-1:0] o_best;
    logic [3:0]         o_idx;
    t_rgbc_out          r_out_data;

    always_comb begin
        h_best = SCORE_W'({ONE, 1'b0});
        h_idx  = CLS_UNKNOWN;
        for (int i = 0; i < 4; i++) begin
            if (r_k_s[i] > h_best) begin
                h_best = r_k_s[i];
                h_idx  = 4'(i);
            end
        end
        o_best = r_h_best;
        o_idx  = r_h_idx;
        for (int i = 0; i < 4; i++) begin
            if (r_h_s[i] > o_best) begin
                o_best = r_h_s[i];
                o_idx  = 4'(i + 4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_best <= h_best;
            r_h_idx  <= h_idx;
            for (int i = 0; i < 4; i++) begin
                r_h_s[i] <= r_k_s[i+4];
            end
            r_h_rej <= r_k_rej;

            r_out_data.colour_class     <= r_h_rej ? CLS_UNKNOWN : o_idx;
            r_out_data.reading_rejected <= r_h_rej;
        end
    end

    assign o_out_data = r_out_data;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `RGBC_ASSERT_NOW(a_rej_unknown, o_out_valid && o_out_data.reading_rejected, o_out_data.colour_class == CLS_UNKNOWN)
    `RGBC_ASSERT_NOW(a_class_range, o_out_valid, o_out_data.colour_class <= CLS_UNKNOWN)
    `RGBC_ASSERT_NOW(a_stall_cause, !o_in_ready, o_out_valid && !i_out_ready)
    `RGBC_ASSERT_NEXT(a_vld_advance, en && r_vld[0], r_vld[1])

endmodule

@@ tb/sv/rgbc_colour_classifier_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGBC colour classifier testbench
// Drives readings through the valid/ready input, writes calibration sets
// between phases, and checks every classification against a fixed-point
// predictor in this file or a given result. Both sides idle at random.
// ----------------------------------------------------------------------------
module rgbc_colour_classifier_tb;
    import rgbc_pkg::*;

    localparam int         LATENCY     = 97;
    localparam longint     CYCLE_LIMIT = 2000000;
    localparam logic [3:0] CLS_RED     = 4'd0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_rgbc_in    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_rgbc_out   o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    rgbc_colour_classifier dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Calibration copy and expected classifications.
    logic [15:0] cal [8];
    t_rgbc_out   expected_classes [$];
    int          fail_count;
    bit          no_idle;
    longint      cycle_count;

    // Ratio score with saturation at 64.
    function automatic longint unsigned ratio_sq(longint unsigned num, longint unsigned den);
        longint unsigned q;
        q = 64'h400000;
        if (den != 0) begin
            q = (num << 16) / den;
            if (q > 64'h400000) q = 64'h400000;
        end
        return (q * q) >> 16;
    endfunction

    function automatic longint unsigned dist_unity(longint unsigned n);
        return (n >= 65536) ? n - 65536 : 65536 - n;
    endfunction

    // Predicts the classification of one reading under the current calibration.
    function automatic t_rgbc_out classify(t_rgbc_in rd);
        longint unsigned ct, w, b, cr, cg, cb, sum, nr, ng, nb, t, grey, best;
        longint unsigned s [8];
        longint unsigned x [3];
        longint unsigned ch [3];
        t_rgbc_out res;
        res.colour_class = CLS_UNKNOWN;
        res.reading_rejected = 1'b1;
        x[0] = rd.red_count;
        x[1] = rd.green_count;
        x[2] = rd.blue_count;
        for (int i = 0; i < 3; i++)
            if (x[i] < 1 || x[i] > VALID_MAX) return res;
        ct = rd.clear_count;
        if (ct < cal[REG_CLEAR_BLACK]) ct = cal[REG_CLEAR_BLACK];
        if (ct > cal[REG_CLEAR_WHITE]) ct = cal[REG_CLEAR_WHITE];
        if (cal[REG_CLEAR_WHITE] == cal[REG_CLEAR_BLACK]) w = 0;
        else if (cal[REG_CLEAR_WHITE] < cal[REG_CLEAR_BLACK]) w = 65536;
        else w = ((ct - cal[REG_CLEAR_BLACK]) << 16)
                 / (cal[REG_CLEAR_WHITE] - cal[REG_CLEAR_BLACK]);
        b = 65536 - w;
        for (int i = 0; i < 3; i++) begin
            longint unsigned wh, bk;
            wh = (cal[5 + i] == 0) ? 1 : cal[5 + i];
            bk = (cal[1 + i] == 0) ? 1 : cal[1 + i];
            ch[i] = (x[i] * w) / wh + (x[i] * b) / bk;
        end
        cr = ch[0]; cg = ch[1]; cb = ch[2];
        sum = cr + cg + cb;
        while (sum >= (64'd1 << 36)) begin
            cr >>= 1; cg >>= 1; cb >>= 1;
            sum = cr + cg + cb;
        end
        if (sum == 0) begin
            nr = 65536; ng = 65536; nb = 65536;
        end else begin
            nr = (3 * 65536 * cr) / sum;
            ng = (3 * 65536 * cg) / sum;
            nb = (3 * 65536 * cb) / sum;
        end
        s[0] = ratio_sq(2 * nr, ng + nb);
        s[1] = ratio_sq(nr + ng, 2 * nb);
        s[2] = ratio_sq(2 * ng, nr + nb);
        s[3] = ratio_sq(ng + nb, 2 * nr);
        s[4] = ratio_sq(2 * nb, nr + ng);
        s[5] = ratio_sq(nb + nr, 2 * ng);
        t = (dist_unity(nr) * dist_unity(ng)) >> 16;
        t = ((t * dist_unity(nb)) >> 16) * 1000;
        if (t > 64'h100000) t = 64'h100000;
        grey = (64'd1 << 32) / (65536 + ((t * t) >> 16));
        s[6] = 4 * ((((w * w) >> 16) * grey) >> 16);
        s[7] = 4 * ((((b * b) >> 16) * grey) >> 16);
        best = 2 * 65536;
        res.reading_rejected = 1'b0;
        for (int i = 0; i < 8; i++)
            if (s[i] > best) begin
                best = s[i];
                res.colour_class = 4'(i);
            end
        return res;
    endfunction

    // Output side: random stall, compare each accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_classes.size() == 0) begin
                $error("unexpected result: colour_class %0d", o_out_data.colour_class);
                fail_count++;
            end else begin
                t_rgbc_out e;
                e = expected_classes.pop_front();
                if (o_out_data.colour_class !== e.colour_class) begin
                    $error("colour_class expected %0d actual %0d",
                           e.colour_class, o_out_data.colour_class);
                    fail_count++;
                end
                if (o_out_data.reading_rejected !== e.reading_rejected) begin
                    $error("reading_rejected expected %0d actual %0d",
                           e.reading_rejected, o_out_data.reading_rejected);
                    fail_count++;
                end
            end
        end
        i_out_ready <= no_idle || ($urandom_range(99) >= 21);
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** rgbc_colour_classifier: FAILED **");
            $finish;
        end
    end

    // Writes one calibration register while the block is idle.
    task automatic write_cal(t_reg_idx idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        cal[idx] = val;
        @(posedge i_clk);
    endtask

    // Waits for all results, then for the pipeline to drain.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_classes.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Sends one reading, with optional random idle beforehand. Valid stays
    // high after acceptance so that back-to-back items need no gap.
    task automatic send_reading(t_rgbc_in rd, t_rgbc_out want, bit typed);
        while (!no_idle && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= rd;
        expected_classes.push_back(typed ? want : classify(rd));
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Colour count, mostly in range, sometimes outside.
    function automatic logic [15:0] pick_colour();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3) return 16'd0;
        if (sel < 6) return 16'($urandom_range(65535, 1023));
        if (sel < 8) return 16'd1023;
        if (sel < 12) return (sel[0]) ? 16'd1 : 16'd1022;
        return 16'($urandom_range(1022, 1));
    endfunction

    typedef struct {
        t_rgbc_in  rd;
        t_rgbc_out want;
        bit        typed;
    } t_directed_row;

    t_directed_row directed [] = '{
        '{'{16'd100, 16'd0, 16'd5, 16'd5},          '{CLS_UNKNOWN, 1'b1}, 1'b1},
        '{'{16'd100, 16'd5, 16'd1023, 16'd5},       '{CLS_UNKNOWN, 1'b1}, 1'b1},
        '{'{16'd100, 16'd5, 16'd5, 16'hFFFF},       '{CLS_UNKNOWN, 1'b1}, 1'b1},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, '{CLS_UNKNOWN, 1'b1}, 1'b1},
        '{'{16'd0, 16'd0, 16'd0, 16'd0},            '{CLS_UNKNOWN, 1'b1}, 1'b1},
        '{'{16'd0, 16'd1022, 16'd1, 16'd1},         '{CLS_RED, 1'b0}, 1'b0},
        '{'{16'd30000, 16'd1022, 16'd1022, 16'd1},  '{CLS_RED, 1'b0}, 1'b0},
        '{'{16'd30000, 16'd1, 16'd1022, 16'd1},     '{CLS_RED, 1'b0}, 1'b0},
        '{'{16'd30000, 16'd1, 16'd1022, 16'd1022},  '{CLS_RED, 1'b0}, 1'b0},
        '{'{16'd30000, 16'd1, 16'd1, 16'd1022},     '{CLS_RED, 1'b0}, 1'b0},
        '{'{16'd30000, 16'd1022, 16'd1, 16'd1022},  '{CLS_RED, 1'b0}, 1'b0},
        '{'{16'hFFFF, 16'd500, 16'd500, 16'd500},   '{CLS_RED, 1'b0}, 1'b0},
        '{'{16'd0, 16'd500, 16'd500, 16'd500},      '{CLS_RED, 1'b0}, 1'b0},
        '{'{16'd32768, 16'd1022, 16'd1022, 16'd1022}, '{CLS_RED, 1'b0}, 1'b0},
        '{'{16'd12345, 16'd1, 16'd1, 16'd1},        '{CLS_RED, 1'b0}, 1'b0}
    };

    // Random calibration set; some sets hit the extremes and special cases.
    task automatic random_calibration(int kind);
        for (int i = 0; i < 8; i++) begin
            logic [15:0] v;
            case (kind)
                0: v = (i == 0 || i == 4) ? 16'h0000 : 16'h0000;
                1: v = 16'hFFFF;
                2: v = (i < 4) ? 16'($urandom_range(60, 0)) : 16'($urandom_range(65535, 200));
                3: v = (i < 4) ? 16'($urandom_range(65535, 30000)) : 16'($urandom_range(2000, 0));
                default: v = 16'($urandom);
            endcase
            write_cal(t_reg_idx'(i), v);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Main stimulus.
    initial begin
        t_rgbc_in rd;
        t_rgbc_out none;
        none = '{CLS_UNKNOWN, 1'b1};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        fail_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        cal = '{16'd0, 16'd1, 16'd1, 16'd1, 16'hFFFF, 16'd1023, 16'd1023, 16'd1023};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_reading(directed[k].rd, directed[k].want, directed[k].typed);
        drain_pipeline();

        // Phases: each with its own calibration, one with no idling at all.
        for (int ph = 0; ph < 10; ph++) begin
            random_calibration(ph % 5 == 4 ? 4 + ph : ph % 5);
            no_idle = (ph == 6);
            for (int n = 0; n < 100; n++) begin
                rd.clear_count = ($urandom_range(9) == 0) ? 16'($urandom_range(1) * 16'hFFFF)
                                                          : 16'($urandom);
                rd.red_count   = pick_colour();
                rd.green_count = pick_colour();
                rd.blue_count  = pick_colour();
                send_reading(rd, none, 1'b0);
                if (n == 50 && ph == 3) begin
                    i_in_valid <= 1'b0;
                    do begin
                        @(posedge i_clk);
                    end while (expected_classes.size() != 0);
                end
            end
            no_idle = 1'b0;
            drain_pipeline();
        end

        if (fail_count == 0 && expected_classes.size() == 0)
            $display("** rgbc_colour_classifier: PASSED **");
        else
            $display("** rgbc_colour_classifier: FAILED **");
        $finish;
    end

endmodule
